/* sv/leb_pkg.sv */
// Shared types and constants for the line edit buffer.
`timescale 1ns / 1ps

package leb_pkg;

  localparam int LINE_DEPTH_DEF = 32;

  localparam int CHAR_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END = 2'd2;

  localparam logic [CHAR_W-1:0] ERASE_RST = 8'd35;
  localparam logic [CHAR_W-1:0] KILL_RST = 8'd64;
  localparam logic [CHAR_W-1:0] END_RST = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic mem_rd;     // read the store at the drain index
    logic load_data;  // move read data into the output register
    logic load_end;   // move the end character into the output register, clear the line
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_end;
    logic count_zero;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

/* sv/leb_ctrl.sv */
// Sequencer for the line edit buffer: accepts characters and drains lines.
`timescale 1ns / 1ps

module leb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  leb_pkg::status_t status,
  output leb_pkg::cmd_t    cmd
);

  leb_pkg::state_t state;
  leb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= leb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      leb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.is_end) begin
            state_next = status.count_zero ? leb_pkg::ST_FINAL : leb_pkg::ST_READ;
          end
        end
      end
      leb_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = leb_pkg::ST_EMIT;
      end
      leb_pkg::ST_EMIT: begin
        // hold until the output register can take the beat
        if (status.out_free) begin
          cmd.load_data = 1'b1;
          state_next = status.rd_last ? leb_pkg::ST_FINAL : leb_pkg::ST_READ;
        end
      end
      leb_pkg::ST_FINAL: begin
        if (status.out_free) begin
          cmd.load_end = 1'b1;
          state_next = leb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = leb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/leb_datapath.sv */
// Line store, fill count, drop flag, configuration and output register.
`timescale 1ns / 1ps

module leb_datapath #(
  parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  leb_pkg::cmd_t                  cmd,
  output leb_pkg::status_t               status,
  input  logic [leb_pkg::CHAR_W-1:0]     in_char,
  input  logic                           cfg_valid,
  input  logic [leb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [leb_pkg::CHAR_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [leb_pkg::CHAR_W-1:0]     out_char,
  output logic                           last,
  output logic                           dropped
);

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LINE_DEPTH);

  logic [leb_pkg::CHAR_W-1:0] line_store [LINE_DEPTH];
  logic [leb_pkg::CHAR_W-1:0] rd_data;
  logic [leb_pkg::CHAR_W-1:0] end_hold;
  logic [leb_pkg::CHAR_W-1:0] erase_char;
  logic [leb_pkg::CHAR_W-1:0] kill_char;
  logic [leb_pkg::CHAR_W-1:0] end_char;
  logic [CW-1:0]              fill_count;
  logic                       drop_seen;
  logic [AW-1:0]              rd_idx;

  logic is_end;
  logic is_erase;
  logic is_kill;
  logic do_push;

  // priority: end, then erase, then kill
  assign is_end   = (in_char == end_char);
  assign is_erase = !is_end && (in_char == erase_char);
  assign is_kill  = !is_end && !is_erase && (in_char == kill_char);
  assign do_push  = cmd.take && !is_end && !is_erase && !is_kill && (fill_count < FULL);

  assign status.is_end     = is_end;
  assign status.count_zero = (fill_count == '0);
  assign status.rd_last    = ((CW'(rd_idx) + CW'(1)) == fill_count);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char <= leb_pkg::ERASE_RST;
      kill_char  <= leb_pkg::KILL_RST;
      end_char   <= leb_pkg::END_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        leb_pkg::CFG_ERASE: erase_char <= cfg_data;
        leb_pkg::CFG_KILL:  kill_char  <= cfg_data;
        leb_pkg::CFG_END:   end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      line_store[fill_count[AW-1:0]] <= in_char;
    end
    if (cmd.mem_rd) begin
      rd_data <= line_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      drop_seen  <= 1'b0;
      rd_idx     <= '0;
    end else begin
      if (cmd.take) begin
        if (is_end) begin
          rd_idx <= '0;
        end else if (is_erase) begin
          if (fill_count != '0) begin
            fill_count <= fill_count - CW'(1);
          end
        end else if (is_kill) begin
          fill_count <= '0;
        end else if (fill_count < FULL) begin
          fill_count <= fill_count + CW'(1);
        end else begin
          drop_seen <= 1'b1;
        end
      end
      if (cmd.load_data) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (cmd.load_end) begin
        fill_count <= '0;
        drop_seen  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_end) begin
      end_hold <= in_char;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_data || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      out_char <= rd_data;
      last     <= 1'b0;
      dropped  <= 1'b0;
    end else if (cmd.load_end) begin
      out_char <= end_hold;
      last     <= 1'b1;
      dropped  <= drop_seen;
    end
  end

endmodule

/* sv/line_edit_buffer.sv */
// Top level of the line edit buffer: controller plus datapath.
// Ordinary, erase and kill characters are taken in ST_IDLE; the next beat is taken at once.
// An end character with N stored characters is drained by one store read and
// one output load per character, then the end beat; output stalls hold the drain.
// Results appear in the cycle after their load, through the output register.
// Synchronous reset empties the line, clears the drop flag and restores the default codes.
`timescale 1ns / 1ps

module line_edit_buffer #(
  parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [leb_pkg::CHAR_W-1:0]     in_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [leb_pkg::CHAR_W-1:0]     out_char,
  output logic                           last,
  output logic                           dropped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [leb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [leb_pkg::CHAR_W-1:0]     cfg_data
);

  leb_pkg::cmd_t    cmd;
  leb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  leb_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_char   (in_char),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .dropped   (dropped)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the line edit buffer.
`timescale 1ns / 1ps

module tb;
  import leb_pkg::*;

  localparam int DEPTH = LINE_DEPTH_DEF;
  localparam int SETTLE = 4;
  localparam int DRAIN = 40;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 55;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {
    ROW_CHAR,
    ROW_REG
  } row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CHAR_W-1:0]     val;
    logic [5:0]            reps;
    logic                  typed;
    logic [CHAR_W-1:0]     end_ch;
    logic                  end_drp;
  } plan_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
    logic              drp;
  } char_beat_t;

  // Typed rows give the final beat of the line they close.
  localparam plan_row_t PLAN [31] = '{
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b1, 8'h0A, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h61, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h62, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h23, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h00, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'hFF, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h23, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h78, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h40, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b1, 8'h0A, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h55, 6'd34, 1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'hAA, 6'd33, 1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h40, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b1, 8'h0A, 1'b1},
    '{ROW_REG,  CFG_ERASE, 8'h00, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_REG,  CFG_KILL,  8'hFF, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_REG,  CFG_END,   8'h00, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h61, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'hFF, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h00, 6'd1,  1'b1, 8'h00, 1'b0},
    '{ROW_REG,  CFG_KILL,  8'h42, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_REG,  CFG_ERASE, 8'h42, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h61, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h62, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h42, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h00, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_REG,  CFG_SPARE, 8'h0A, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h0A, 6'd1,  1'b0, 8'h00, 1'b0},
    '{ROW_CHAR, CFG_SPARE, 8'h00, 6'd1,  1'b0, 8'h00, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_char = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_char;
  logic                  last;
  logic                  dropped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CHAR_W-1:0]     cfg_data = '0;

  // Line model: store, fill level, drop flag and the three codes.
  logic [CHAR_W-1:0]  line_mem [DEPTH];
  int                 line_fill;
  logic               line_drop;
  logic [CHAR_W-1:0]  code_erase;
  logic [CHAR_W-1:0]  code_kill;
  logic [CHAR_W-1:0]  code_end;

  char_beat_t released_q [$];
  char_beat_t want;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         idle_on = 1'b0;

  line_edit_buffer #(
    .LINE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last),
    .dropped   (dropped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void edit_line(input logic [CHAR_W-1:0] c);
    char_beat_t b;
    if (c == code_end) begin
      for (int k = 0; k < line_fill; k++) begin
        b.ch = line_mem[k];
        b.lst = 1'b0;
        b.drp = 1'b0;
        released_q.push_back(b);
      end
      b.ch = c;
      b.lst = 1'b1;
      b.drp = line_drop;
      released_q.push_back(b);
      line_fill = 0;
      line_drop = 1'b0;
    end else if (c == code_erase) begin
      if (line_fill > 0) line_fill = line_fill - 1;
    end else if (c == code_kill) begin
      line_fill = 0;
    end else if (line_fill < DEPTH) begin
      line_mem[line_fill] = c;
      line_fill = line_fill + 1;
    end else begin
      line_drop = 1'b1;
    end
  endfunction

  // Offer one character and hold it until taken; optionally idle first.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    edit_line(c);
  endtask

  // Drop valid and let every pending beat out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ERASE: code_erase = val;
      CFG_KILL:  code_kill = val;
      CFG_END:   code_end = val;
      default: ;
    endcase
  endtask

  // Mostly whole lines of random bytes with some erase and kill; now and then
  // leave a line open, and now and then wait for the block to drain.
  task automatic random_lines(input int count);
    int sent;
    int len;
    int r;
    logic [CHAR_W-1:0] c;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(99) < 25) ? $urandom_range(28, 40) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 10) c = code_erase;
        else if (r < 13) c = code_kill;
        else c = CHAR_W'($urandom_range(255));
        send_char(c);
        sent++;
      end
      if ($urandom_range(99) >= 10) begin
        send_char(code_end);
        sent++;
      end
      if ($urandom_range(99) < 5) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (released_q.size() == 0) begin
        $display("%0t: unexpected beat char=%h last=%b dropped=%b",
                 $time, out_char, last, dropped);
        mismatches++;
      end else begin
        want = released_q.pop_front();
        if ({out_char, last, dropped} !== want) begin
          $display("%0t: expected char=%h last=%b dropped=%b, got char=%h last=%b dropped=%b",
                   $time, want.ch, want.lst, want.drp, out_char, last, dropped);
          mismatches++;
        end
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1 ||
        (cfg_valid && cfg_ready) === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    line_fill = 0;
    line_drop = 1'b0;
    code_erase = ERASE_RST;
    code_kill = KILL_RST;
    code_end = END_RST;
    for (int k = 0; k < DEPTH; k++) line_mem[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    foreach (PLAN[n]) begin
      if (PLAN[n].op == ROW_REG) begin
        write_reg(PLAN[n].reg_idx, PLAN[n].val);
      end else begin
        for (int k = 0; k < PLAN[n].reps; k++) send_char(PLAN[n].val);
        if (PLAN[n].typed) begin
          released_q[$] = '{PLAN[n].end_ch, 1'b1, PLAN[n].end_drp};
        end
      end
    end

    // Defaults first, then random codes with no idling at all, then fixed and random codes with idling.
    write_reg(CFG_ERASE, ERASE_RST);
    write_reg(CFG_KILL, KILL_RST);
    write_reg(CFG_END, END_RST);
    random_lines(RANDOM_PER_PHASE);

    idle_on = 1'b0;
    write_reg(CFG_ERASE, CHAR_W'($urandom_range(255)));
    write_reg(CFG_KILL, CHAR_W'($urandom_range(255)));
    write_reg(CFG_END, CHAR_W'($urandom_range(255)));
    random_lines(RANDOM_PER_PHASE);

    idle_on = 1'b1;
    write_reg(CFG_ERASE, 8'hFF);
    write_reg(CFG_KILL, 8'h00);
    write_reg(CFG_END, 8'h80);
    write_reg(CFG_SPARE, CHAR_W'($urandom_range(255)));
    random_lines(RANDOM_PER_PHASE);

    write_reg(CFG_ERASE, CHAR_W'($urandom_range(255)));
    write_reg(CFG_KILL, CHAR_W'($urandom_range(255)));
    write_reg(CFG_END, CHAR_W'($urandom_range(255)));
    random_lines(RANDOM_PER_PHASE);
    send_char(code_end);

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && released_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/leb_pkg.sv
sv/leb_ctrl.sv
sv/leb_datapath.sv
sv/line_edit_buffer.sv
tb/tb.sv
